### rtl/core/stpseq_pkg.sv
package stpseq_pkg;

  localparam logic [15:0] DEFAULT_PULSE = 16'd2000;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  localparam logic [7:0] CMD_FF    = 8'd101;
  localparam logic [7:0] CMD_FR    = 8'd113;
  localparam logic [7:0] CMD_FH    = 8'd119;
  localparam logic [7:0] CMD_RF    = 8'd99;
  localparam logic [7:0] CMD_RR    = 8'd122;
  localparam logic [7:0] CMD_RH    = 8'd120;
  localparam logic [7:0] CMD_HF    = 8'd100;
  localparam logic [7:0] CMD_HR    = 8'd97;
  localparam logic [7:0] CMD_HH    = 8'd115;
  localparam logic [7:0] CMD_CLEAR = 8'd114;
  localparam logic [7:0] CMD_LIFT  = 8'd102;
  localparam logic [7:0] CMD_LOWER = 8'd118;

  typedef struct packed {
    logic set_dirs;
    dir_t dir_a;
    dir_t dir_b;
    logic clear;
    logic lift;
    logic lower;
  } cmd_dec_t;

  // Coil nibble for a phase; same bit order on both axes.
  function automatic logic [3:0] coil_nibble(input logic [1:0] phase);
    logic [3:0] nib;
    case (phase)
      2'd0:    nib = 4'b1000;
      2'd1:    nib = 4'b0010;
      2'd2:    nib = 4'b0100;
      default: nib = 4'b0001;
    endcase
    return nib;
  endfunction

endpackage

### rtl/core/two_axis_stepper_command_sequencer_unit.sv
// An accepted input item reaches its result on m_axis through the input register,
// then the result register.
// Throughput: one item per cycle; s_axis_tready stays high while the result
// register is empty or being taken.
// Reset (rst, synchronous): both stages empty, phases/directions/coordinates
// cleared, lift line set, pulse count and pulse length 2000.
module two_axis_stepper_command_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // drill_pulse_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
  input  logic        s_axis_tuser,   // [0] action: 0 command, 1 tick
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [7:0] coil_pattern, [23:8] pos_x,
                                      // [39:24] pos_y, [40] drill_up,
                                      // [41] drill_down, [47:42] zero
);

  logic        pulse_ticks;
  logic [15:0] drill_pulse_ticks;
  logic        in_valid;
  logic        in_action;
  logic [7:0]  in_cmd;
  logic        out_free;
  logic        adv;
  logic        is_cmd;
  stpseq_pkg::cmd_dec_t dec;
  logic [1:0]  phase_a_next;
  logic [1:0]  phase_b_next;
  logic [15:0] coord_x_next;
  logic [15:0] coord_y_next;
  logic        lift_line;
  logic        lower_line;
  logic [15:0] pulse_countdown;
  logic        lift_next;
  logic        lower_next;
  logic [15:0] countdown_next;
  logic        out_valid;
  logic [41:0] out_data;

  assign pulse_ticks   = 1'b0;
  assign out_free      = !out_valid || m_axis_tready;
  assign adv           = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign is_cmd        = !in_action;

  always_ff @(posedge clk) begin
    if (rst) begin
      drill_pulse_ticks <= stpseq_pkg::DEFAULT_PULSE;
    end else if (cfg_wr_en) begin
      drill_pulse_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_cmd    <= s_axis_tdata;
    end
  end

  stpseq_cmd_dec u_dec (
    .cmd_byte (in_cmd),
    .dec      (dec)
  );

  stpseq_axis u_axis_a (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .is_cmd     (is_cmd),
    .set_dir    (dec.set_dirs),
    .dir_new    (dec.dir_a),
    .clear      (dec.clear),
    .phase_next (phase_a_next),
    .coord_next (coord_x_next)
  );

  stpseq_axis u_axis_b (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .is_cmd     (is_cmd),
    .set_dir    (dec.set_dirs),
    .dir_new    (dec.dir_b),
    .clear      (dec.clear),
    .phase_next (phase_b_next),
    .coord_next (coord_y_next)
  );

  always_comb begin
    lift_next      = lift_line;
    lower_next     = lower_line;
    countdown_next = pulse_countdown;
    if (is_cmd) begin
      if (dec.lift) begin
        lift_next      = 1'b1;
        countdown_next = drill_pulse_ticks;
      end
      if (dec.lower) begin
        lower_next     = 1'b1;
        countdown_next = drill_pulse_ticks;
      end
    end else if (pulse_countdown > 16'd1) begin
      countdown_next = pulse_countdown - 16'd1;
    end else begin
      countdown_next = 16'd0;
      lift_next      = pulse_ticks;
      lower_next     = pulse_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lift_line       <= 1'b1;
      lower_line      <= 1'b0;
      pulse_countdown <= stpseq_pkg::DEFAULT_PULSE;
    end else if (adv) begin
      lift_line       <= lift_next;
      lower_line      <= lower_next;
      pulse_countdown <= countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= {lower_next, lift_next, coord_y_next, coord_x_next,
                   stpseq_pkg::coil_nibble(phase_a_next),
                   stpseq_pkg::coil_nibble(phase_b_next)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_data};

endmodule

### rtl/core/stpseq_cmd_dec.sv
module stpseq_cmd_dec (
  input  logic [7:0]                cmd_byte,
  output stpseq_pkg::cmd_dec_t      dec
);

  always_comb begin
    dec.set_dirs = 1'b1;
    dec.dir_a    = stpseq_pkg::DIR_HOLD;
    dec.dir_b    = stpseq_pkg::DIR_HOLD;
    dec.clear    = 1'b0;
    dec.lift     = 1'b0;
    dec.lower    = 1'b0;
    unique case (cmd_byte)
      stpseq_pkg::CMD_FF: begin
        dec.dir_a = stpseq_pkg::DIR_FWD;
        dec.dir_b = stpseq_pkg::DIR_FWD;
      end
      stpseq_pkg::CMD_FR: begin
        dec.dir_a = stpseq_pkg::DIR_FWD;
        dec.dir_b = stpseq_pkg::DIR_REV;
      end
      stpseq_pkg::CMD_FH: begin
        dec.dir_a = stpseq_pkg::DIR_FWD;
      end
      stpseq_pkg::CMD_RF: begin
        dec.dir_a = stpseq_pkg::DIR_REV;
        dec.dir_b = stpseq_pkg::DIR_FWD;
      end
      stpseq_pkg::CMD_RR: begin
        dec.dir_a = stpseq_pkg::DIR_REV;
        dec.dir_b = stpseq_pkg::DIR_REV;
      end
      stpseq_pkg::CMD_RH: begin
        dec.dir_a = stpseq_pkg::DIR_REV;
      end
      stpseq_pkg::CMD_HF: begin
        dec.dir_b = stpseq_pkg::DIR_FWD;
      end
      stpseq_pkg::CMD_HR: begin
        dec.dir_b = stpseq_pkg::DIR_REV;
      end
      stpseq_pkg::CMD_HH: begin
      end
      stpseq_pkg::CMD_CLEAR: begin
        dec.clear = 1'b1;
      end
      stpseq_pkg::CMD_LIFT: begin
        dec.lift = 1'b1;
      end
      stpseq_pkg::CMD_LOWER: begin
        dec.lower = 1'b1;
      end
      default: begin
        // unknown: keep held directions
        dec.set_dirs = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/stpseq_axis.sv
module stpseq_axis (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                is_cmd,
  input  logic                set_dir,
  input  stpseq_pkg::dir_t    dir_new,
  input  logic                clear,
  output logic [1:0]          phase_next,
  output logic [15:0]         coord_next
);

  logic [1:0]       phase;
  stpseq_pkg::dir_t dir_held;
  logic [15:0]      coord;
  stpseq_pkg::dir_t dir_next;
  logic [15:0]      coord_base;

  always_comb begin
    dir_next   = dir_held;
    coord_base = coord;
    phase_next = phase;
    if (is_cmd) begin
      if (set_dir) begin
        dir_next = dir_new;
      end
      if (clear) begin
        coord_base = 16'd0;
      end
      case (dir_next)
        stpseq_pkg::DIR_FWD: begin
          phase_next = phase + 2'd1;
          coord_base = coord_base + 16'd1;
        end
        stpseq_pkg::DIR_REV: begin
          phase_next = phase - 2'd1;
          coord_base = coord_base - 16'd1;
        end
        default: begin
        end
      endcase
    end
    coord_next = coord_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 2'd0;
      dir_held <= stpseq_pkg::DIR_HOLD;
      coord    <= 16'd0;
    end else if (en) begin
      phase    <= phase_next;
      dir_held <= dir_next;
      coord    <= coord_next;
    end
  end

endmodule

### rtl/core/stpseq_chk.sv
module stpseq_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_coil_onehot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot(m_axis_tdata[7:4]) && $onehot(m_axis_tdata[3:0]))
    else $error("coil pattern not one phase per axis");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind two_axis_stepper_command_sequencer_unit stpseq_chk u_stpseq_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
